FILE: design/swt_pkg.sv
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types and constants for the stream window tracker.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ESTATE_W = 2;
  localparam int unsigned DISP_W   = 2;
  localparam int unsigned CHUNK_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned DivSteps = WORD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DivSteps);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_OPENED  = 3'd1,
    CMD_SKIP    = 3'd2,
    CMD_ADVANCE = 3'd3,
    CMD_QUERY   = 3'd4,
    CMD_CLOSED  = 3'd5
  } cmd_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHUNK_SIZE      = 3'd0,
    REG_WINDOW_SIZE     = 3'd1,
    REG_START_THRESHOLD = 3'd2,
    REG_RING_END        = 3'd3,
    REG_RING_SIZE       = 3'd4
  } cfg_reg_t;

  localparam logic [ESTATE_W-1:0] ESTATE_FINISHED = 2'd3;

  localparam logic [DISP_W-1:0] DISP_BEFORE = 2'd0;
  localparam logic [DISP_W-1:0] DISP_EMPTY  = 2'd1;
  localparam logic [DISP_W-1:0] DISP_PAST   = 2'd2;
  localparam logic [DISP_W-1:0] DISP_INSIDE = 2'd3;

  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 8'd2;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // latch the accepted word
    logic exec;      // apply state update, seed divider
    logic div_step;  // one quotient bit
    logic finish;    // load output register
  } swt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_query;
  } swt_status_t;

endpackage

FILE: design/swt_in_if.sv
// ----------------------------------------------------------------------------
// swt_in_if
// Input channel: command word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface swt_in_if;
  logic                           valid;
  logic                           ready;
  logic [swt_pkg::CMD_W-1:0]      cmd;
  logic [swt_pkg::WORD_W-1:0]     value;
  logic [swt_pkg::ESTATE_W-1:0]   event_state;

  modport source (output valid, output cmd, output value, output event_state,
                  input ready);
  modport sink   (input valid, input cmd, input value, input event_state,
                  output ready);
endinterface

FILE: design/swt_out_if.sv
// ----------------------------------------------------------------------------
// swt_out_if
// Output channel: result word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface swt_out_if;
  logic                         valid;
  logic                         ready;
  logic [swt_pkg::DISP_W-1:0]   disposition;
  logic                         remove_request;
  logic [swt_pkg::WORD_W-1:0]   ring_position;
  logic [swt_pkg::WORD_W-1:0]   read_budget;

  modport source (output valid, output disposition, output remove_request,
                  output ring_position, output read_budget, input ready);
  modport sink   (input valid, input disposition, input remove_request,
                  input ring_position, input read_budget, output ready);
endinterface

FILE: design/stream_window_tracker.sv
// ----------------------------------------------------------------------------
// stream_window_tracker
// Follows the file read window of one streamed playback event.
// ----------------------------------------------------------------------------
//  channel  dir  handshake       payload
//  in_ch    in   valid/ready     cmd, value, event_state
//  out_ch   out  valid/ready     disposition, remove_request, ring_position,
//                                read_budget
//  cfg      in   cfg_we          cfg_index, cfg_data
//
//  One word at a time. Query: latched, executed, then divided bit-serially,
//  one quotient bit per cycle, then finished into the output register; the
//  next word is taken after the finish step. Other commands skip the divide.
//  A new word is taken while the previous result still sits in the output
//  register; a stalled output holds the sequencer in its finish step.
//  Synchronous reset clears state and loads register defaults.
// ----------------------------------------------------------------------------
module stream_window_tracker (
  input  logic                          clk,
  input  logic                          rst,
  swt_in_if.sink                        in_ch,
  swt_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [swt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swt_pkg::WORD_W-1:0]    cfg_data
);
  import swt_pkg::*;

  swt_cmd_t    cmd;
  swt_status_t status;

  swt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  swt_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_cmd         (in_ch.cmd),
    .in_value       (in_ch.value),
    .in_event_state (in_ch.event_state),
    .disposition    (out_ch.disposition),
    .remove_request (out_ch.remove_request),
    .ring_position  (out_ch.ring_position),
    .read_budget    (out_ch.read_budget)
  );

endmodule

FILE: design/swt_ctrl.sv
// ----------------------------------------------------------------------------
// swt_ctrl
// Sequencer: accept, execute, divide (queries only), finish.
// ----------------------------------------------------------------------------
module swt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swt_pkg::swt_cmd_t     cmd,
  input  swt_pkg::swt_status_t  status
);
  import swt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic                   out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd.load_in  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.div_step = 1'b0;
    cmd.finish   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = status.is_query ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_CNT_W'(DivSteps - 1)) state_next = ST_FIN;
      end
      ST_FIN: begin
        // hold until the output register can take the word
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC) div_cnt <= '0;
      else if (state == ST_DIV) div_cnt <= div_cnt + 1'b1;
      if (cmd.finish) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

FILE: design/swt_dp.sv
// ----------------------------------------------------------------------------
// swt_dp
// Datapath: config registers, window state, bit-serial divider, output regs.
// ----------------------------------------------------------------------------
module swt_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  swt_pkg::swt_cmd_t             cmd,
  output swt_pkg::swt_status_t          status,
  input  logic                          cfg_we,
  input  logic [swt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swt_pkg::WORD_W-1:0]    cfg_data,
  input  logic [swt_pkg::CMD_W-1:0]     in_cmd,
  input  logic [swt_pkg::WORD_W-1:0]    in_value,
  input  logic [swt_pkg::ESTATE_W-1:0]  in_event_state,
  output logic [swt_pkg::DISP_W-1:0]    disposition,
  output logic                          remove_request,
  output logic [swt_pkg::WORD_W-1:0]    ring_position,
  output logic [swt_pkg::WORD_W-1:0]    read_budget
);
  import swt_pkg::*;

  // configuration
  logic [CHUNK_W-1:0] chunk_size;
  logic [WORD_W-1:0]  window_size, start_threshold, ring_end, ring_size;

  // latched input word
  logic [CMD_W-1:0]    cur_cmd;
  logic [WORD_W-1:0]   cur_value;
  logic [ESTATE_W-1:0] cur_estate;

  // window state
  logic [WORD_W-1:0] file_offset, consumed_bytes, ring_location;
  logic [WORD_W-1:0] budget_bytes, cached_size;

  // divider
  logic [WORD_W-1:0]  avail;
  logic [WORD_W-1:0]  quot;
  logic [CHUNK_W-1:0] rem;
  logic [CHUNK_W-1:0] divisor;
  logic [CHUNK_W:0]   rem_shift;
  logic               rem_ge;

  logic [WORD_W-1:0] span, avail_c, remaining, step, ring_sum, boundary;
  logic [DISP_W-1:0] disp_c;

  assign status.is_query = (cur_cmd == CMD_QUERY);

  assign span      = window_size - consumed_bytes;
  assign avail_c   = (budget_bytes > span) ? (budget_bytes - span) : '0;
  assign remaining = cur_value - file_offset;
  assign step      = (cur_value > cached_size) ? cached_size : cur_value;
  assign ring_sum  = ring_location + step;

  assign divisor   = (chunk_size == '0) ? CHUNK_W'(1) : chunk_size;
  assign rem_shift = {rem, quot[WORD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, divisor});
  assign boundary  = start_threshold + quot;

  always_comb begin
    if (start_threshold > cur_value) disp_c = DISP_BEFORE;
    else if (start_threshold == cur_value)
      disp_c = (avail == '0) ? DISP_EMPTY : DISP_INSIDE;
    else if (cur_value < boundary) disp_c = DISP_INSIDE;
    else disp_c = (avail == '0) ? DISP_EMPTY : DISP_PAST;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size      <= CHUNK_RESET;
      window_size     <= '0;
      start_threshold <= '0;
      ring_end        <= '0;
      ring_size       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHUNK_SIZE:      chunk_size      <= cfg_data[CHUNK_W-1:0];
        REG_WINDOW_SIZE:     window_size     <= cfg_data;
        REG_START_THRESHOLD: start_threshold <= cfg_data;
        REG_RING_END:        ring_end        <= cfg_data;
        REG_RING_SIZE:       ring_size       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_offset    <= '0;
      consumed_bytes <= '0;
      ring_location  <= '0;
      budget_bytes   <= '0;
      cached_size    <= '0;
    end else if (cmd.exec) begin
      case (cur_cmd)
        CMD_CLEAR: begin
          file_offset    <= '0;
          consumed_bytes <= '0;
          ring_location  <= '0;
          budget_bytes   <= '0;
          cached_size    <= '0;
        end
        CMD_OPENED: begin
          cached_size <= cur_value;
          if (remaining < budget_bytes) budget_bytes <= remaining;
        end
        CMD_SKIP: begin
          consumed_bytes <= consumed_bytes + cur_value;
          file_offset    <= file_offset + cur_value;
          budget_bytes   <= budget_bytes - cur_value;
        end
        CMD_ADVANCE: begin
          ring_location <= (ring_sum >= ring_end) ? (ring_sum - ring_size) : ring_sum;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cur_cmd    <= in_cmd;
      cur_value  <= in_value;
      cur_estate <= in_event_state;
    end
    // restoring divide, quotient shifts in where the dividend shifts out
    if (cmd.exec) begin
      avail <= avail_c;
      quot  <= avail_c;
      rem   <= '0;
    end else if (cmd.div_step) begin
      quot <= {quot[WORD_W-2:0], rem_ge};
      rem  <= rem_ge ? CHUNK_W'(rem_shift - {1'b0, divisor}) : rem_shift[CHUNK_W-1:0];
    end
    if (cmd.finish) begin
      disposition    <= (cur_cmd == CMD_QUERY) ? disp_c : DISP_BEFORE;
      remove_request <= (cur_cmd == CMD_CLOSED) && (cur_estate == ESTATE_FINISHED);
      ring_position  <= ring_location;
      read_budget    <= budget_bytes;
    end
  end

endmodule

FILE: sim/swt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swt_checker
// Watches both channels and the register port of the stream window tracker,
// predicts each result word from the accepted command words and compares the
// words that come out, field by field, in order.
// ----------------------------------------------------------------------------
module swt_checker (
  input  logic                          clk,
  input  logic                          rst,
  swt_in_if                             in_ch,
  swt_out_if                            out_ch,
  input  logic                          cfg_we,
  input  logic [swt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [swt_pkg::WORD_W-1:0]    cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            checked,
  output int                            queries,
  output int                            removals
);
  import swt_pkg::*;

  typedef struct packed {
    logic [DISP_W-1:0] disposition;
    logic              remove_request;
    logic [WORD_W-1:0] ring_position;
    logic [WORD_W-1:0] read_budget;
  } window_result_t;

  // register shadows
  logic [CHUNK_W-1:0] reg_chunk;
  logic [WORD_W-1:0]  reg_window;
  logic [WORD_W-1:0]  reg_threshold;
  logic [WORD_W-1:0]  reg_ring_end;
  logic [WORD_W-1:0]  reg_ring_size;

  // tracked window state
  logic [WORD_W-1:0]  read_offset;
  logic [WORD_W-1:0]  bytes_taken;
  logic [WORD_W-1:0]  ring_loc;
  logic [WORD_W-1:0]  budget;
  logic [WORD_W-1:0]  size_seen;

  window_result_t window_result_q[$];
  int err_cnt, done_cnt, query_cnt, remove_cnt;

  function automatic void clear_window();
    read_offset = '0;
    bytes_taken = '0;
    ring_loc    = '0;
    budget      = '0;
    size_seen   = '0;
  endfunction

  function automatic logic [DISP_W-1:0] classify(input logic [WORD_W-1:0] pos);
    logic [WORD_W-1:0] span, avail, divisor, boundary;
    span     = reg_window - bytes_taken;
    avail    = (budget > span) ? budget - span : '0;
    // a zero chunk divides as one
    divisor  = (reg_chunk == '0) ? 32'd1 : {{(WORD_W-CHUNK_W){1'b0}}, reg_chunk};
    boundary = reg_threshold + avail / divisor;
    if (reg_threshold > pos) return DISP_BEFORE;
    if (reg_threshold == pos) return (avail == '0) ? DISP_EMPTY : DISP_INSIDE;
    if (pos < boundary) return DISP_INSIDE;
    return (avail == '0) ? DISP_EMPTY : DISP_PAST;
  endfunction

  function automatic window_result_t track_word(input logic [CMD_W-1:0]    cmd,
                                                input logic [WORD_W-1:0]   value,
                                                input logic [ESTATE_W-1:0] estate);
    window_result_t    res;
    logic [WORD_W-1:0] left, step, pos;
    res = '0;
    case (cmd)
      CMD_CLEAR: clear_window();
      CMD_OPENED: begin
        size_seen = value;
        left = value - read_offset;
        if (left < budget) budget = left;
      end
      CMD_SKIP: begin
        bytes_taken = bytes_taken + value;
        read_offset = read_offset + value;
        budget      = budget - value;
      end
      CMD_ADVANCE: begin
        step = (value > size_seen) ? size_seen : value;
        pos  = ring_loc + step;
        if (pos >= reg_ring_end) pos = pos - reg_ring_size;
        ring_loc = pos;
      end
      CMD_QUERY: res.disposition = classify(value);
      CMD_CLOSED: res.remove_request = (estate == ESTATE_FINISHED);
      default: ;
    endcase
    res.ring_position = ring_loc;
    res.read_budget   = budget;
    return res;
  endfunction

  always @(posedge clk) begin
    window_result_t want;
    if (rst) begin
      reg_chunk     = CHUNK_RESET;
      reg_window    = '0;
      reg_threshold = '0;
      reg_ring_end  = '0;
      reg_ring_size = '0;
      clear_window();
      window_result_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CHUNK_SIZE:      reg_chunk     = cfg_data[CHUNK_W-1:0];
          REG_WINDOW_SIZE:     reg_window    = cfg_data;
          REG_START_THRESHOLD: reg_threshold = cfg_data;
          REG_RING_END:        reg_ring_end  = cfg_data;
          REG_RING_SIZE:       reg_ring_size = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        want = track_word(in_ch.cmd, in_ch.value, in_ch.event_state);
        if (in_ch.cmd == CMD_QUERY) query_cnt++;
        if (want.remove_request) remove_cnt++;
        window_result_q.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (window_result_q.size() == 0) begin
          $error("result word with no prediction pending");
          err_cnt++;
        end else begin
          want = window_result_q.pop_front();
          done_cnt++;
          if (out_ch.disposition !== want.disposition) begin
            $error("disposition: expected %0d, got %0d", want.disposition,
                   out_ch.disposition);
            err_cnt++;
          end
          if (out_ch.remove_request !== want.remove_request) begin
            $error("remove_request: expected %0d, got %0d", want.remove_request,
                   out_ch.remove_request);
            err_cnt++;
          end
          if (out_ch.ring_position !== want.ring_position) begin
            $error("ring_position: expected %h, got %h", want.ring_position,
                   out_ch.ring_position);
            err_cnt++;
          end
          if (out_ch.read_budget !== want.read_budget) begin
            $error("read_budget: expected %h, got %h", want.read_budget,
                   out_ch.read_budget);
            err_cnt++;
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending    <= window_result_q.size();
    checked    <= done_cnt;
    queries    <= query_cnt;
    removals   <= remove_cnt;
  end

endmodule

FILE: sim/tb_stream_window_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stream_window_tracker
// Drives command words and register settings into the stream window tracker
// with random idle gaps on both channels, a long output stall and full
// drains; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_stream_window_tracker;
  import swt_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int MAX_GAP         = 14;
  localparam int LONG_HOLD       = 400;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 200;
  localparam int PRESSURE_WORDS  = 30;
  localparam int TAIL_CYCLES     = 40;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  int mismatches, pending, checked, queries, removals;

  bit                no_gaps;
  int                hold_asks;
  int                holds_served;
  int                settings_used;
  logic [WORD_W-1:0] cur_threshold;

  swt_in_if  in_ch();
  swt_out_if out_ch();

  stream_window_tracker dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  swt_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .checked(checked),
    .queries(queries), .removals(removals)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int draw_gap();
    if (no_gaps || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [ESTATE_W-1:0] pick_estate();
    return ESTATE_W'($urandom_range(0, 3));
  endfunction

  task automatic send_word(input logic [CMD_W-1:0]    cmd,
                           input logic [WORD_W-1:0]   value,
                           input logic [ESTATE_W-1:0] estate);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= cmd;
    in_ch.value       <= value;
    in_ch.event_state <= estate;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [WORD_W-1:0] chunk_word,
                              input logic [WORD_W-1:0] window,
                              input logic [WORD_W-1:0] threshold,
                              input logic [WORD_W-1:0] ring_end,
                              input logic [WORD_W-1:0] ring_size);
    cfg_reg_t          regs [5] = '{REG_CHUNK_SIZE, REG_WINDOW_SIZE, REG_START_THRESHOLD,
                                    REG_RING_END, REG_RING_SIZE};
    logic [WORD_W-1:0] vals [5];
    vals = '{chunk_word, window, threshold, ring_end, ring_size};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    // an index past the last register must be ignored
    cfg_index <= CFG_IDX_W'(REG_RING_SIZE + $urandom_range(1, 3));
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_threshold = threshold;
    settings_used++;
  endtask

  function automatic logic [WORD_W-1:0] pick_size();
    case ($urandom_range(0, 4))
      0: return 32'hFFFF_FFFF - $urandom_range(0, 4000);
      1: return $urandom;
      2: return '0;
      default: return $urandom_range(0, 4000);
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_skip();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 300);
  endfunction

  function automatic logic [WORD_W-1:0] pick_step();
    if ($urandom_range(0, 7) == 0) return $urandom;
    return $urandom_range(0, 600);
  endfunction

  // positions mostly land around the start of the window
  function automatic logic [WORD_W-1:0] pick_pos();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return cur_threshold;
      2: return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
      default: return cur_threshold + $urandom_range(0, 2500) - 8;
    endcase
  endfunction

  task automatic run_phase(input int count);
    int                sent;
    int                burst;
    int                pick;
    logic [CMD_W-1:0]  noise_cmd;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 6) == 0) begin
        noise_cmd = CMD_W'($urandom_range(0, 7));
        send_word(noise_cmd, $urandom, pick_estate());
        if (noise_cmd <= CMD_CLOSED) sent++;
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_word(CMD_CLEAR, $urandom, pick_estate());
          sent++;
        end
        send_word(CMD_OPENED, pick_size(), pick_estate());
        sent++;
        burst = $urandom_range(3, 12);
        repeat (burst) begin
          pick = $urandom_range(0, 9);
          if (pick < 2) send_word(CMD_SKIP, pick_skip(), pick_estate());
          else if (pick < 4) send_word(CMD_ADVANCE, pick_step(), pick_estate());
          else if (pick < 9) send_word(CMD_QUERY, pick_pos(), pick_estate());
          else send_word(CMD_CLOSED, $urandom, pick_estate());
          sent++;
        end
      end
    end
  endtask

  // output side: random stalls, plus one long hold when the sender asks
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (hold_asks != holds_served) begin
        gap = LONG_HOLD;
        holds_served++;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin
    logic [WORD_W-1:0] ring_end;
    no_gaps       = 1'b0;
    hold_asks     = 0;
    holds_served  = 0;
    settings_used = 0;
    cur_threshold = '0;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_CHUNK_SIZE;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.cmd         <= CMD_CLEAR;
    in_ch.value       <= '0;
    in_ch.event_state <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values first
    send_word(CMD_OPENED, 32'd10, 2'd0);
    send_word(CMD_QUERY, 32'd5, 2'd0);
    drain();

    // directed: zero chunk, known window so the before, inside and past answers are reached
    program_regs(32'h0000_0100, 32'd100, 32'd1000, 32'd50, 32'd40);
    send_word(CMD_CLEAR, 32'd0, 2'd0);
    send_word(CMD_OPENED, 32'd500, 2'd1);
    send_word(CMD_SKIP, 32'd20, 2'd2);          // budget wraps below zero
    send_word(CMD_OPENED, 32'd500, 2'd3);       // clamps it back
    send_word(CMD_QUERY, 32'd999, 2'd0);
    send_word(CMD_QUERY, 32'd1000, 2'd0);
    send_word(CMD_QUERY, 32'd1100, 2'd0);
    send_word(CMD_QUERY, 32'd1400, 2'd0);
    send_word(CMD_QUERY, 32'hFFFF_FFFF, 2'd0);
    send_word(CMD_QUERY, 32'd0, 2'd0);
    send_word(CMD_ADVANCE, 32'd30, 2'd0);
    send_word(CMD_ADVANCE, 32'd30, 2'd0);       // crosses ring end
    send_word(CMD_ADVANCE, 32'hFFFF_FFFF, 2'd0); // step capped by file size
    send_word(CMD_ADVANCE, 32'd0, 2'd0);
    send_word(CMD_CLOSED, 32'd0, ESTATE_FINISHED);
    send_word(CMD_CLOSED, 32'hFFFF_FFFF, 2'd0);
    send_word(CMD_SPARE_LO, 32'hFFFF_FFFF, ESTATE_FINISHED);
    send_word(CMD_SPARE_HI, 32'h5555_AAAA, ESTATE_FINISHED);
    send_word(CMD_SKIP, 32'hFFFF_FFFF, 2'd0);
    send_word(CMD_OPENED, 32'hFFFF_FFFF, 2'd0);
    send_word(CMD_SKIP, 32'd0, 2'd0);
    send_word(CMD_QUERY, 32'd1000, 2'd0);
    send_word(CMD_CLEAR, 32'hFFFF_FFFF, 2'd3);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain();
      case (p)
        0: program_regs(32'd1, '0, '0, '0, '0);
        1: program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF);
        2: program_regs(32'h0000_0100, $urandom_range(0, 3000), $urandom_range(0, 5000),
                        $urandom_range(1, 3000), $urandom_range(0, 1000));
        default: begin
          ring_end = $urandom_range(0, 3000);
          program_regs({24'($urandom_range(0, 255)), 8'($urandom_range(1, 255))},
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3000),
                       ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000),
                       ring_end,
                       ($urandom_range(0, 4) == 0) ? $urandom
                                                   : $urandom_range(0, ring_end));
        end
      endcase
      if (p == 3) begin
        // long output stall while the sender keeps pushing
        hold_asks++;
        no_gaps = 1'b1;
        run_phase(PRESSURE_WORDS);
        no_gaps = 1'b0;
        run_phase(WORDS_PER_PHASE - PRESSURE_WORDS);
      end else begin
        no_gaps = (p == 5);
        run_phase(WORDS_PER_PHASE);
        no_gaps = 1'b0;
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("summary: %0d result words checked over %0d register settings",
             checked, settings_used);
    $display("summary: %0d queries, %0d removal requests, one long output stall",
             queries, removals);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: stream_window_tracker.f
design/swt_pkg.sv
design/swt_in_if.sv
design/swt_out_if.sv
design/swt_ctrl.sv
design/swt_dp.sv
design/stream_window_tracker.sv
sim/swt_checker.sv
sim/tb_stream_window_tracker.sv
